// ===== src/assert_macros.svh =====
// Assertion macros used by the RTL top level of the buddy allocator.
// Depends on nothing; synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BAC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define BAC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define BAC_ASSERT(lbl, clk, rstn, prop)
`define BAC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== src/bac_pkg.sv =====
// Package of the buddy allocator: sizes, widths, datapath commands and controller states.
// Depends on nothing; used by every module of the block.
package bac_pkg;

  localparam int POOL_LEVELS  = 10;
  localparam int HEADER_BYTES = 16;
  localparam int MIN_LEVEL    = 5;

  localparam int GRAN_W   = POOL_LEVELS - MIN_LEVEL;
  localparam int NUM_GRAN = 1 << GRAN_W;
  localparam int NUM_LVL  = POOL_LEVELS - MIN_LEVEL + 1;
  localparam int LI_W     = $clog2(NUM_LVL);
  localparam int LVL_W    = 4;
  localparam int SZ_W     = 10;
  localparam int OFF_W    = 10;
  localparam int ADDR_W   = POOL_LEVELS + 1;
  localparam int BYTES_W  = 18;
  localparam int ST_W     = 2;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_NO_FIT  = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD_FREE = 2'd2;

  typedef logic [GRAN_W-1:0] gran_t;
  typedef logic [LVL_W-1:0]  lvl_t;

  // Datapath operations, one per cycle.
  typedef enum logic [3:0] {
    DP_NOP, DP_CAPTURE, DP_TAKE, DP_FAIL_ALLOC, DP_UL_READ, DP_UL_LINK, DP_UL_CLR,
    DP_SPLIT, DP_ALLOC_FIN, DP_PUSH_A, DP_PUSH_B, DP_FREE_OK, DP_FAIL_FREE,
    DP_MERGE_TAKE, DP_MERGE_UP, DP_MERGE_FIN
  } dp_op_t;

  // Source of the single granule read address.
  typedef enum logic [1:0] {RD_CHK, RD_BUD, RD_T} rd_sel_t;

  typedef struct packed {
    dp_op_t  op;
    rd_sel_t rd_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic found;
    logic can_split;
    logic check_ok;
    logic can_merge;
    logic head_ok;
  } dp_stat_t;

  typedef enum logic [3:0] {
    S_IDLE, S_A_FIND, S_UL_READ, S_UL_LINK, S_UL_CLR, S_SPLIT, S_PUSH_A, S_PUSH_B,
    S_F_CHECK, S_MERGE, S_MERGE_UP, S_DONE
  } state_t;

  // True when a block of the given level holds sz payload bytes.
  function automatic logic fits(input lvl_t lvl, input logic [SZ_W-1:0] sz);
    logic [BYTES_W-1:0] bytes;
    bytes = BYTES_W'(1) << lvl;
    return (bytes > BYTES_W'(HEADER_BYTES)) &&
           ((bytes - BYTES_W'(HEADER_BYTES)) >= BYTES_W'(sz));
  endfunction

endpackage

// ===== src/bac_ctrl.sv =====
// Controller of the buddy allocator: sequences search, unlink, split, merge and push.
// Depends on bac_pkg.
module bac_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  bac_pkg::dp_stat_t stat,
  output bac_pkg::dp_cmd_t  cmd,
  output logic              busy,
  output logic              done
);
  import bac_pkg::*;

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (start) state_nxt = S_A_FIND;
      S_A_FIND:   state_nxt = stat.is_free ? (stat.check_ok ? S_MERGE : S_DONE)
                                           : (stat.found ? S_UL_READ : S_DONE);
      S_UL_READ:  state_nxt = S_UL_LINK;
      S_UL_LINK:  state_nxt = S_UL_CLR;
      S_UL_CLR:   state_nxt = stat.is_free ? S_MERGE_UP : S_SPLIT;
      S_SPLIT:    state_nxt = stat.can_split ? S_PUSH_A : S_DONE;
      S_PUSH_A:   state_nxt = stat.head_ok ? S_PUSH_B : (stat.is_free ? S_DONE : S_SPLIT);
      S_PUSH_B:   state_nxt = stat.is_free ? S_DONE : S_SPLIT;
      S_F_CHECK:  state_nxt = stat.check_ok ? S_MERGE : S_DONE;
      S_MERGE:    state_nxt = stat.can_merge ? S_UL_READ : S_PUSH_A;
      S_MERGE_UP: state_nxt = S_MERGE;
      S_DONE:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Outputs: the first state after capture handles both allocate search and free check.
  always_comb begin
    cmd.op     = DP_NOP;
    cmd.rd_sel = RD_T;
    busy       = (state_r != S_IDLE);
    done       = (state_r == S_DONE);
    unique case (state_r)
      S_IDLE:     if (start) cmd.op = DP_CAPTURE;
      S_A_FIND: begin
        cmd.rd_sel = RD_CHK;
        if (stat.is_free) begin
          cmd.op = stat.check_ok ? DP_FREE_OK : DP_FAIL_FREE;
        end else begin
          cmd.op = stat.found ? DP_TAKE : DP_FAIL_ALLOC;
        end
      end
      S_UL_READ:  cmd.op = DP_UL_READ;
      S_UL_LINK:  cmd.op = DP_UL_LINK;
      S_UL_CLR:   cmd.op = DP_UL_CLR;
      S_SPLIT:    cmd.op = stat.can_split ? DP_SPLIT : DP_ALLOC_FIN;
      S_PUSH_A:   cmd.op = DP_PUSH_A;
      S_PUSH_B:   cmd.op = DP_PUSH_B;
      S_F_CHECK: begin
        cmd.rd_sel = RD_CHK;
        cmd.op     = stat.check_ok ? DP_FREE_OK : DP_FAIL_FREE;
      end
      S_MERGE: begin
        cmd.rd_sel = RD_BUD;
        cmd.op     = stat.can_merge ? DP_MERGE_TAKE : DP_MERGE_FIN;
      end
      S_MERGE_UP: cmd.op = DP_MERGE_UP;
      S_DONE:     cmd.op = DP_NOP;
      default:    cmd.op = DP_NOP;
    endcase
  end

endmodule

// ===== src/bac_dpath.sv =====
// Datapath of the buddy allocator: free list heads, granule tables and result registers.
// Depends on bac_pkg; driven by bac_ctrl through one command word a cycle.
module bac_dpath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bac_pkg::dp_cmd_t            cmd,
  input  logic                        in_operation,
  input  logic [bac_pkg::SZ_W-1:0]    in_request_size,
  input  logic [bac_pkg::OFF_W-1:0]   in_payload_offset_in,
  output bac_pkg::dp_stat_t           stat,
  output logic [bac_pkg::OFF_W-1:0]   res_off,
  output logic [bac_pkg::LVL_W-1:0]   res_lvl,
  output logic [bac_pkg::ST_W-1:0]    res_st
);
  import bac_pkg::*;

  // Free list heads and granule tables.
  gran_t             head_r   [NUM_LVL];
  logic              hok_r    [NUM_LVL];
  lvl_t              glvl_r   [NUM_GRAN];
  logic              gfree_r  [NUM_GRAN];
  gran_t             next_r   [NUM_GRAN];
  logic              nok_r    [NUM_GRAN];
  gran_t             prev_r   [NUM_GRAN];
  logic              pok_r    [NUM_GRAN];

  // Request and walk registers.
  logic              op_r;
  logic [SZ_W-1:0]   sz_r;
  logic [OFF_W-1:0]  pin_r;
  gran_t             g_r, t_r, lp_r, ln_r;
  logic              lpok_r, lnok_r;
  lvl_t              lvl_r;
  logic [OFF_W-1:0]  res_off_r;
  lvl_t              res_lvl_r;
  logic [ST_W-1:0]   res_st_r;

  logic [LI_W-1:0]   li, found_li;
  logic              found;
  logic [ADDR_W-1:0] off, lmask;
  gran_t             chk_g, bud, up, rd_a;
  lvl_t              rd_lvl;
  logic              rd_free;

  // Lowest level whose list is non-empty and whose block fits the request.
  always_comb begin
    found    = 1'b0;
    found_li = '0;
    for (int i = NUM_LVL - 1; i >= 0; i--) begin
      if (hok_r[i] && fits(LVL_W'(i + MIN_LEVEL), sz_r)) begin
        found    = 1'b1;
        found_li = LI_W'(i);
      end
    end
  end

  // Address arithmetic and the single granule read.
  always_comb begin
    li     = LI_W'(lvl_r - LVL_W'(MIN_LEVEL));
    off    = ADDR_W'(pin_r) - ADDR_W'(HEADER_BYTES);
    chk_g  = off[POOL_LEVELS-1:MIN_LEVEL];
    bud    = g_r ^ (GRAN_W'(1) << (lvl_r - LVL_W'(MIN_LEVEL)));
    up     = g_r + (GRAN_W'(1) << (lvl_r - LVL_W'(MIN_LEVEL + 1)));
    unique case (cmd.rd_sel)
      RD_CHK:  rd_a = chk_g;
      RD_BUD:  rd_a = bud;
      RD_T:    rd_a = t_r;
      default: rd_a = t_r;
    endcase
    rd_lvl  = glvl_r[rd_a];
    rd_free = gfree_r[rd_a];
    lmask   = (ADDR_W'(1) << rd_lvl) - ADDR_W'(1);
  end

  // Status toward the controller.
  always_comb begin
    stat.is_free   = op_r;
    stat.found     = found;
    stat.can_split = (lvl_r > LVL_W'(MIN_LEVEL)) && fits(lvl_r - LVL_W'(1), sz_r);
    stat.check_ok  = (ADDR_W'(pin_r) >= ADDR_W'(HEADER_BYTES)) &&
                     (off < (ADDR_W'(1) << POOL_LEVELS)) &&
                     (off[MIN_LEVEL-1:0] == '0) && !rd_free &&
                     (rd_lvl >= LVL_W'(MIN_LEVEL)) && (rd_lvl <= LVL_W'(POOL_LEVELS)) &&
                     ((off & lmask) == '0);
    stat.can_merge = (lvl_r < LVL_W'(POOL_LEVELS)) && rd_free && (rd_lvl == lvl_r);
    stat.head_ok   = hok_r[li];
  end

  // Request and walk registers.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_CAPTURE: begin
        op_r  <= in_operation;
        sz_r  <= (in_request_size == '0) ? SZ_W'(1) : in_request_size;
        pin_r <= in_payload_offset_in;
      end
      DP_TAKE: begin
        g_r   <= head_r[found_li];
        t_r   <= head_r[found_li];
        lvl_r <= LVL_W'(found_li) + LVL_W'(MIN_LEVEL);
      end
      DP_FAIL_ALLOC: begin
        res_off_r <= '0;
        res_lvl_r <= '0;
        res_st_r  <= ST_NO_FIT;
      end
      DP_UL_READ: begin
        lp_r   <= prev_r[t_r];
        lpok_r <= pok_r[t_r];
        ln_r   <= next_r[t_r];
        lnok_r <= nok_r[t_r];
      end
      DP_SPLIT: begin
        lvl_r <= lvl_r - LVL_W'(1);
        t_r   <= up;
      end
      DP_ALLOC_FIN: begin
        res_off_r <= OFF_W'((ADDR_W'(g_r) << MIN_LEVEL) + ADDR_W'(HEADER_BYTES));
        res_lvl_r <= lvl_r;
        res_st_r  <= ST_OK;
      end
      DP_FREE_OK: begin
        g_r   <= chk_g;
        lvl_r <= rd_lvl;
      end
      DP_FAIL_FREE: begin
        res_off_r <= pin_r;
        res_lvl_r <= '0;
        res_st_r  <= ST_BAD_FREE;
      end
      DP_MERGE_TAKE: t_r <= bud;
      DP_MERGE_UP: begin
        if (t_r < g_r) g_r <= t_r;
        lvl_r <= lvl_r + LVL_W'(1);
      end
      DP_MERGE_FIN: begin
        t_r       <= g_r;
        res_off_r <= pin_r;
        res_lvl_r <= lvl_r;
        res_st_r  <= ST_OK;
      end
      default: ;
    endcase
  end

  // Free list heads and granule tables; reset holds one free top-level block at granule 0.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LVL; i++) begin
        head_r[i] <= '0;
        hok_r[i]  <= (i == NUM_LVL - 1);
      end
      for (int i = 0; i < NUM_GRAN; i++) begin
        glvl_r[i]  <= (i == 0) ? LVL_W'(POOL_LEVELS) : '0;
        gfree_r[i] <= (i == 0);
        next_r[i]  <= '0;
        nok_r[i]   <= 1'b0;
        prev_r[i]  <= '0;
        pok_r[i]   <= 1'b0;
      end
    end else begin
      unique case (cmd.op)
        DP_UL_LINK: begin
          if (lpok_r) begin
            next_r[lp_r] <= ln_r;
            nok_r[lp_r]  <= lnok_r;
          end else begin
            head_r[li] <= ln_r;
            hok_r[li]  <= lnok_r;
          end
          if (lnok_r) begin
            prev_r[ln_r] <= lp_r;
            pok_r[ln_r]  <= lpok_r;
          end
        end
        DP_UL_CLR: begin
          nok_r[t_r] <= 1'b0;
          pok_r[t_r] <= 1'b0;
        end
        DP_SPLIT: begin
          glvl_r[up]  <= lvl_r - LVL_W'(1);
          gfree_r[up] <= 1'b1;
        end
        DP_ALLOC_FIN: begin
          glvl_r[g_r]  <= lvl_r;
          gfree_r[g_r] <= 1'b0;
        end
        DP_FREE_OK:   gfree_r[chk_g] <= 1'b1;
        DP_MERGE_FIN: begin
          glvl_r[g_r]  <= lvl_r;
          gfree_r[g_r] <= 1'b1;
        end
        DP_PUSH_A: begin
          next_r[t_r] <= head_r[li];
          nok_r[t_r]  <= hok_r[li];
          pok_r[t_r]  <= 1'b0;
          if (!hok_r[li]) begin
            head_r[li] <= t_r;
            hok_r[li]  <= 1'b1;
          end
        end
        DP_PUSH_B: begin
          prev_r[head_r[li]] <= t_r;
          pok_r[head_r[li]]  <= 1'b1;
          head_r[li]         <= t_r;
        end
        default: ;
      endcase
    end
  end

  assign res_off = res_off_r;
  assign res_lvl = res_lvl_r;
  assign res_st  = res_st_r;

endmodule

// ===== src/buddy_allocator_core.sv =====
// Top level of the buddy allocator: controller plus datapath.
// Depends on bac_pkg, bac_ctrl, bac_dpath and assert_macros.svh.
//
//   Channel   Handshake            Word
//   request   start high, busy low in_operation, in_request_size, in_payload_offset_in
//   result    out_valid one cycle  out_payload_offset, out_block_level, out_status
//
// An allocate runs from acceptance through the search, the unlink states (read, link,
// clear), a split check and push of the upper half per split level, and the strobe. A free
// runs through the check, then per merged level the buddy test, the unlink states and the
// level step, then the push onto the target list and the strobe. A rejected word goes from
// the search straight to the strobe. The next word is taken only after the strobe, in idle.
// Synchronous reset leaves one free top-level block at granule 0.
// The result strobe lasts one cycle and the receiver cannot stall it.
`include "assert_macros.svh"
module buddy_allocator_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_operation,
  input  logic [bac_pkg::SZ_W-1:0]    in_request_size,
  input  logic [bac_pkg::OFF_W-1:0]   in_payload_offset_in,
  output logic                        out_valid,
  output logic [bac_pkg::OFF_W-1:0]   out_payload_offset,
  output logic [bac_pkg::LVL_W-1:0]   out_block_level,
  output logic [bac_pkg::ST_W-1:0]    out_status
);
  import bac_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer.
  bac_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (out_valid)
  );

  // Tables and result registers.
  bac_dpath u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .in_operation         (in_operation),
    .in_request_size      (in_request_size),
    .in_payload_offset_in (in_payload_offset_in),
    .stat                 (stat),
    .res_off              (out_payload_offset),
    .res_lvl              (out_block_level),
    .res_st               (out_status)
  );

  // Checks.
  `BAC_ASSERT(a_accept_busy, clk, rst_n, (start && !busy) |=> busy)
  `BAC_ASSERT(a_done_idle, clk, rst_n, out_valid |=> (!busy && !out_valid))
  `BAC_ASSERT(a_valid_busy, clk, rst_n, out_valid |-> busy)
  `BAC_ASSERT(a_nofit_zero, clk, rst_n, (out_valid && out_status == ST_NO_FIT) |-> (out_payload_offset == '0 && out_block_level == '0))
  `BAC_ASSERT(a_status_code, clk, rst_n, out_valid |-> (out_status != 2'd3))

endmodule

// ===== sim/buddy_allocator_checker.sv =====
// Checker for the buddy allocator core: watches request and result words, predicts each result.
// Depends on bac_pkg for widths and status codes; instantiated by buddy_allocator_core_tb.
module buddy_allocator_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  logic                      in_operation,
  input  logic [bac_pkg::SZ_W-1:0]  in_request_size,
  input  logic [bac_pkg::OFF_W-1:0] in_payload_offset_in,
  input  logic                      out_valid,
  input  logic [bac_pkg::OFF_W-1:0] out_payload_offset,
  input  logic [bac_pkg::LVL_W-1:0] out_block_level,
  input  logic [bac_pkg::ST_W-1:0]  out_status,
  output int                        errors,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import bac_pkg::*;

  typedef struct {
    logic [OFF_W-1:0] off;
    lvl_t             lvl;
    logic [ST_W-1:0]  st;
  } alloc_word_t;

  alloc_word_t expected_words[$];

  // Shadow of the allocator tables.
  gran_t list_head [NUM_LVL];
  logic  list_head_v [NUM_LVL];
  lvl_t  blk_level [NUM_GRAN];
  logic  blk_free [NUM_GRAN];
  gran_t link_nxt [NUM_GRAN];
  logic  link_nxt_v [NUM_GRAN];
  gran_t link_prv [NUM_GRAN];
  logic  link_prv_v [NUM_GRAN];

  function automatic bit holds(int lvl, int sz);
    int bytes;
    bytes = 1 << lvl;
    return bytes > HEADER_BYTES && bytes - HEADER_BYTES >= sz;
  endfunction

  function automatic void push_free(int li, gran_t g);
    link_nxt[g] = list_head[li];
    link_nxt_v[g] = list_head_v[li];
    if (list_head_v[li]) begin
      link_prv[list_head[li]] = g;
      link_prv_v[list_head[li]] = 1'b1;
    end
    link_prv_v[g] = 1'b0;
    list_head[li] = g;
    list_head_v[li] = 1'b1;
  endfunction

  function automatic void unlink_free(int li, gran_t g);
    if (link_prv_v[g]) begin
      link_nxt[link_prv[g]] = link_nxt[g];
      link_nxt_v[link_prv[g]] = link_nxt_v[g];
    end else begin
      list_head[li] = link_nxt[g];
      list_head_v[li] = link_nxt_v[g];
    end
    if (link_nxt_v[g]) begin
      link_prv[link_nxt[g]] = link_prv[g];
      link_prv_v[link_nxt[g]] = link_prv_v[g];
    end
    link_nxt_v[g] = 1'b0;
    link_prv_v[g] = 1'b0;
  endfunction

  function automatic void clear_pool();
    for (int i = 0; i < NUM_LVL; i++) begin
      list_head[i] = '0;
      list_head_v[i] = 1'b0;
    end
    for (int i = 0; i < NUM_GRAN; i++) begin
      blk_level[i] = '0;
      blk_free[i] = 1'b0;
      link_nxt[i] = '0;
      link_nxt_v[i] = 1'b0;
      link_prv[i] = '0;
      link_prv_v[i] = 1'b0;
    end
    blk_level[0] = lvl_t'(POOL_LEVELS);
    blk_free[0] = 1'b1;
    list_head_v[NUM_LVL-1] = 1'b1;
  endfunction

  // Works out the result word of one request and updates the shadow tables.
  function automatic alloc_word_t serve_request(logic op, int sz, int pin);
    alloc_word_t w;
    int lvl, off;
    bit ok;
    gran_t g, up, bud;
    w = '{off: '0, lvl: '0, st: ST_OK};
    if (op == 1'b0) begin
      if (sz == 0) sz = 1;
      ok = 0;
      for (lvl = MIN_LEVEL; lvl <= POOL_LEVELS; lvl++) begin
        if (list_head_v[lvl-MIN_LEVEL] && holds(lvl, sz)) begin
          ok = 1;
          break;
        end
      end
      if (!ok) begin
        w.st = ST_NO_FIT;
      end else begin
        g = list_head[lvl-MIN_LEVEL];
        unlink_free(lvl - MIN_LEVEL, g);
        while (lvl > MIN_LEVEL && holds(lvl - 1, sz)) begin
          lvl--;
          up = g + gran_t'(1 << (lvl - MIN_LEVEL));
          blk_level[up] = lvl_t'(lvl);
          blk_free[up] = 1'b1;
          push_free(lvl - MIN_LEVEL, up);
        end
        blk_level[g] = lvl_t'(lvl);
        blk_free[g] = 1'b0;
        w.off = OFF_W'(int'(g) * (1 << MIN_LEVEL) + HEADER_BYTES);
        w.lvl = lvl_t'(lvl);
      end
    end else begin
      w.off = OFF_W'(pin);
      ok = pin >= HEADER_BYTES;
      lvl = 0;
      g = '0;
      if (ok) begin
        off = pin - HEADER_BYTES;
        ok = off < (1 << POOL_LEVELS) && off % (1 << MIN_LEVEL) == 0;
      end
      if (ok) begin
        g = gran_t'(off >> MIN_LEVEL);
        lvl = blk_level[g];
        ok = !blk_free[g] && lvl >= MIN_LEVEL && lvl <= POOL_LEVELS &&
             off % (1 << lvl) == 0;
      end
      if (!ok) begin
        w.st = ST_BAD_FREE;
      end else begin
        blk_free[g] = 1'b1;
        // Merge upward while the buddy is a free block of the same level.
        while (lvl < POOL_LEVELS) begin
          bud = g ^ gran_t'(1 << (lvl - MIN_LEVEL));
          if (!blk_free[bud] || blk_level[bud] != lvl) break;
          unlink_free(lvl - MIN_LEVEL, bud);
          if (bud < g) g = bud;
          lvl++;
        end
        blk_level[g] = lvl_t'(lvl);
        blk_free[g] = 1'b1;
        push_free(lvl - MIN_LEVEL, g);
        w.lvl = lvl_t'(lvl);
      end
    end
    return w;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  // Results are checked before the request of the same edge is predicted.
  always @(posedge clk) begin
    alloc_word_t w;
    if (!rst_n) begin
      clear_pool();
      expected_words.delete();
    end else begin
      if (out_valid) begin
        if (expected_words.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          w = expected_words.pop_front();
          if (out_payload_offset !== w.off)
            report_mismatch($sformatf("offset %0d, expected %0d", out_payload_offset, w.off));
          if (out_block_level !== w.lvl)
            report_mismatch($sformatf("level %0d, expected %0d", out_block_level, w.lvl));
          if (out_status !== w.st)
            report_mismatch($sformatf("status %0d, expected %0d", out_status, w.st));
        end
      end
      if (start && !busy)
        expected_words.push_back(serve_request(in_operation, int'(in_request_size),
                                               int'(in_payload_offset_in)));
    end
    pending = expected_words.size();
  end
endmodule

// ===== sim/buddy_allocator_core_tb.sv =====
// Top of the buddy allocator testbench: clock, reset, request stimulus and the verdict.
// Depends on bac_pkg, buddy_allocator_core and buddy_allocator_checker.
module buddy_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bac_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;

  logic clk, rst_n, start, busy, in_operation, out_valid;
  logic [SZ_W-1:0]  in_request_size;
  logic [OFF_W-1:0] in_payload_offset_in, out_payload_offset;
  logic [LVL_W-1:0] out_block_level;
  logic [ST_W-1:0]  out_status;
  int errors, pending;
  logic took;
  int idle_pct, stalled_cycles, words_sent, allocs_ok, frees_ok, rejects;

  // Operation of each word in flight, and what the pool is known to hold.
  logic  op_in_flight[$];
  int    live_offsets[$];
  bit    gran_written[NUM_GRAN];

  buddy_allocator_core dut (.*);

  buddy_allocator_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) took <= rst_n && start && !busy;

  // Learn from each result which blocks are live; nothing is compared here.
  always @(posedge clk) begin
    logic op;
    if (rst_n && start && !busy) op_in_flight.push_back(in_operation);
    if (rst_n && out_valid && op_in_flight.size() > 0) begin
      op = op_in_flight.pop_front();
      if (out_status != ST_OK) rejects++;
      else if (op) frees_ok++;
      else begin
        allocs_ok++;
        live_offsets.push_back(int'(out_payload_offset));
        gran_written[(int'(out_payload_offset) - HEADER_BYTES) >> MIN_LEVEL] = 1'b1;
      end
    end
  end

  // Watchdog on cycles with no word moving either way.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) stalled_cycles <= 0;
    else stalled_cycles <= stalled_cycles + 1;
    if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles", stalled_cycles);
      $display("buddy_allocator_core_tb: FAIL");
      $finish;
    end
  end

  task automatic send_word(logic op, int sz, int pin);
    @(posedge clk);
    start <= 1'b1;
    in_operation <= op;
    in_request_size <= SZ_W'(sz);
    in_payload_offset_in <= OFF_W'(pin);
    do @(negedge clk); while (!took);
    words_sent++;
  endtask

  task automatic idle_gap();
    while ($urandom_range(99, 0) < idle_pct) begin
      @(posedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic drain_results();
    @(posedge clk);
    start <= 1'b0;
    while (op_in_flight.size() > 0) @(negedge clk);
  endtask

  // Free requests: mostly live blocks, also double frees, stale granules and bad offsets.
  task automatic random_free();
    int pick, idx, pin, g;
    pick = $urandom_range(99, 0);
    if (pick < 60 && live_offsets.size() > 0) begin
      idx = $urandom_range(live_offsets.size() - 1, 0);
      pin = live_offsets[idx];
      live_offsets.delete(idx);
    end else if (pick < 85) begin
      do g = $urandom_range(NUM_GRAN - 1, 0); while (!gran_written[g]);
      pin = g * (1 << MIN_LEVEL) + HEADER_BYTES;
    end else begin
      do pin = $urandom_range(1023, 0);
      while (pin >= HEADER_BYTES && (pin - HEADER_BYTES) % (1 << MIN_LEVEL) == 0);
    end
    send_word(1'b1, 0, pin);
  endtask

  task automatic random_alloc();
    int sz;
    case ($urandom_range(9, 0))
      0:       sz = $urandom_range(1023, 0);
      1:       sz = $urandom_range(500, 0);
      default: sz = $urandom_range(112, 0);
    endcase
    send_word(1'b0, sz, $urandom_range(1023, 0));
  endtask

  initial begin
    int phase_pct[4];
    phase_pct = '{0, 66, 0, 35};
    rst_n = 1'b0;
    start = 1'b0;
    in_operation = 1'b0;
    in_request_size = '0;
    in_payload_offset_in = '0;
    gran_written[0] = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: whole pool, no fit, double and malformed frees, a split chain and merges.
    idle_pct = 0;
    send_word(1'b0, 1008, 0);
    send_word(1'b0, 1, 0);
    send_word(1'b1, 0, 16);
    send_word(1'b1, 0, 16);
    send_word(1'b1, 0, 0);
    send_word(1'b1, 0, 17);
    send_word(1'b1, 0, 1023);
    send_word(1'b0, 0, 1023);
    send_word(1'b0, 16, 0);
    send_word(1'b0, 17, 0);
    send_word(1'b0, 500, 0);
    send_word(1'b0, 496, 0);
    send_word(1'b0, 1023, 0);
    drain_results();
    live_offsets.delete();
    send_word(1'b1, 0, 48);
    send_word(1'b1, 0, 16);
    send_word(1'b1, 0, 80);
    send_word(1'b1, 0, 528);
    send_word(1'b1, 0, 528);

    // Random phases with and without sender idling; each pauses once until drained.
    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_pct[p];
      for (int i = 0; i < 125; i++) begin
        idle_gap();
        if ($urandom_range(99, 0) < (live_offsets.size() > 8 ? 65 : 40)) random_free();
        else random_alloc();
        if (i == 60) drain_results();
      end
    end

    drain_results();
    repeat (60) @(posedge clk);
    $display("Sent %0d words: %0d allocations and %0d frees went through, %0d rejected.",
             words_sent, allocs_ok, frees_ok, rejects);
    if (pending != 0) $display("%0d expected result words never arrived", pending);
    if (errors == 0 && pending == 0) begin
      $display("buddy_allocator_core_tb: PASS");
    end else begin
      $display("buddy_allocator_core_tb: FAIL");
    end
    $finish;
  end
endmodule
